@@ rtl/tswd_pkg.sv @@
package tswd_pkg;

  localparam int MAX_AXES = 6;

  localparam logic [15:0] FLAGS_PREFIX = 16'hcccc;

  typedef enum logic [2:0] {
    ST_FIRST,
    ST_CONTROL,
    ST_DIM,
    ST_MAXW,
    ST_PADW,
    ST_WALK
  } back_state_t;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_DIM16,
    MODE_DIM24,
    MODE_DIM32
  } axis_mode_t;

  typedef struct packed {
    logic [31:0] word;
    logic        prefix;
  } word_entry_t;

  typedef struct packed {
    logic [2:0]  axis;
    logic [31:0] dim;
    logic [31:0] max_dim;
    logic [7:0]  pad;
    logic [15:0] flags;
    logic        last;
  } result_t;

endpackage

@@ rtl/tswd_front.sv @@
module tswd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [31:0]          word,
  output logic                 full,
  output logic                 head_valid,
  output tswd_pkg::word_entry_t head,
  input  logic                 head_take
);
  import tswd_pkg::*;

  word_entry_t mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pushing;
  logic        popping;
  word_entry_t entry;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign pushing    = push && !full;
  assign popping    = head_take && head_valid;
  assign head       = mem[rd_ptr];

  // tag words that carry the flags prefix so the back end only checks a bit
  always_comb begin
    entry.word   = word;
    entry.prefix = (word[31:16] == FLAGS_PREFIX);
  end

  always_ff @(posedge clk) begin
    if (pushing) begin
      mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (pushing) wr_ptr <= ~wr_ptr;
      if (popping) rd_ptr <= ~rd_ptr;
      if (pushing && !popping) count <= count + 2'd1;
      else if (popping && !pushing) count <= count - 2'd1;
    end
  end

endmodule

@@ rtl/tswd_back.sv @@
module tswd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [2:0]            rank_setting,
  input  logic                  head_valid,
  input  tswd_pkg::word_entry_t head,
  output logic                  head_take,
  output logic                  res_valid,
  output tswd_pkg::result_t     res,
  input  logic                  res_full
);
  import tswd_pkg::*;

  back_state_t state, state_next;
  logic [1:0]  stage, stage_next;
  logic [2:0]  axis_index, axis_index_next;
  logic [23:0] control_held, control_held_next;
  logic [15:0] flags_held, flags_held_next;
  logic [31:0] dim_held, dim_held_next;
  logic [31:0] max_held, max_held_next;
  logic [7:0]  pad_held, pad_held_next;

  logic [3:0]  group;
  logic [2:0]  rank_eff;
  logic        last_axis;
  logic [16:0] sum16;
  logic [31:0] w;

  assign w     = head.word;
  assign sum16 = {1'b0, w[15:0]} + {9'd0, w[23:16]};

  always_comb begin
    case (axis_index)
      3'd0:    group = control_held[3:0];
      3'd1:    group = control_held[7:4];
      3'd2:    group = control_held[11:8];
      3'd3:    group = control_held[15:12];
      3'd4:    group = control_held[19:16];
      3'd5:    group = control_held[23:20];
      default: group = 4'd0;
    endcase
  end

  // out-of-range rank saturates into 1..MAX_AXES
  always_comb begin
    if (rank_setting == 3'd0) rank_eff = 3'd1;
    else if (rank_setting > 3'(MAX_AXES)) rank_eff = 3'(MAX_AXES);
    else rank_eff = rank_setting;
  end

  assign last_axis = ({1'b0, axis_index} + 4'd1) >= {1'b0, rank_eff};

  always_comb begin
    state_next        = state;
    stage_next        = stage;
    axis_index_next   = axis_index;
    control_held_next = control_held;
    flags_held_next   = flags_held;
    dim_held_next     = dim_held;
    max_held_next     = max_held;
    pad_held_next     = pad_held;
    head_take         = 1'b0;
    res_valid         = 1'b0;
    res.axis          = axis_index;
    res.dim           = (stage == 2'd0) ? 32'd1 : dim_held;
    res.max_dim       = (stage == 2'd0) ? 32'd1 : max_held;
    res.pad           = (stage == 2'd0) ? 8'd0 : pad_held;
    res.flags         = flags_held;
    res.last          = last_axis;
    case (state)
      ST_FIRST: begin
        if (head_valid) begin
          head_take = 1'b1;
          if (head.prefix) begin
            flags_held_next = w[15:0];
            state_next      = ST_CONTROL;
          end else begin
            flags_held_next   = 16'd0;
            control_held_next = w[23:0];
            axis_index_next   = 3'd0;
            stage_next        = 2'd0;
            state_next        = ST_WALK;
          end
        end
      end
      ST_CONTROL: begin
        if (head_valid) begin
          head_take         = 1'b1;
          control_held_next = w[23:0];
          axis_index_next   = 3'd0;
          stage_next        = 2'd0;
          state_next        = ST_WALK;
        end
      end
      ST_DIM: begin
        if (head_valid) begin
          head_take = 1'b1;
          case (axis_mode_t'(group[1:0]))
            MODE_DIM16: begin
              dim_held_next = {16'd0, w[15:0]};
              max_held_next = {15'd0, sum16};
              pad_held_next = w[31:24];
            end
            MODE_DIM24: begin
              dim_held_next = {8'd0, w[23:0]};
              max_held_next = {8'd0, w[23:0]};
              pad_held_next = w[31:24];
            end
            default: begin
              dim_held_next = w;
              max_held_next = w;
              pad_held_next = 8'd0;
            end
          endcase
          stage_next = 2'd1;
          state_next = ST_WALK;
        end
      end
      ST_MAXW: begin
        if (head_valid) begin
          head_take     = 1'b1;
          max_held_next = w;
          stage_next    = 2'd2;
          state_next    = ST_WALK;
        end
      end
      ST_PADW: begin
        if (head_valid) begin
          head_take     = 1'b1;
          pad_held_next = w[7:0];
          stage_next    = 2'd3;
          state_next    = ST_WALK;
        end
      end
      ST_WALK: begin
        // one axis step per cycle while the result queue has room: wait for a word or emit the axis
        if (stage == 2'd0 && group[1:0] != 2'd0) begin
          state_next = ST_DIM;
        end else if (stage <= 2'd1 && group[2]) begin
          if (stage == 2'd0) begin
            dim_held_next = 32'd1;
            max_held_next = 32'd1;
            pad_held_next = 8'd0;
          end
          state_next = ST_MAXW;
        end else if (stage <= 2'd2 && group[3]) begin
          if (stage == 2'd0) begin
            dim_held_next = 32'd1;
            max_held_next = 32'd1;
            pad_held_next = 8'd0;
          end
          state_next = ST_PADW;
        end else if (!res_full) begin
          res_valid = 1'b1;
          if (last_axis) begin
            flags_held_next = 16'd0;
            axis_index_next = 3'd0;
            state_next      = ST_FIRST;
          end else begin
            axis_index_next = axis_index + 3'd1;
            stage_next      = 2'd0;
          end
        end
      end
      default: state_next = ST_FIRST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_FIRST;
      stage        <= 2'd0;
      axis_index   <= 3'd0;
      control_held <= 24'd0;
      flags_held   <= 16'd0;
    end else begin
      state        <= state_next;
      stage        <= stage_next;
      axis_index   <= axis_index_next;
      control_held <= control_held_next;
      flags_held   <= flags_held_next;
    end
  end

  always_ff @(posedge clk) begin
    dim_held <= dim_held_next;
    max_held <= max_held_next;
    pad_held <= pad_held_next;
  end

endmodule

@@ rtl/tswd_out_q.sv @@
module tswd_out_q (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  tswd_pkg::result_t res,
  output logic              res_full,
  output logic              empty,
  output tswd_pkg::result_t head,
  input  logic              pop
);
  import tswd_pkg::*;

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       writing;
  logic       reading;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign writing  = res_valid && !res_full;
  assign reading  = pop && !empty;
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (writing) begin
      mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (writing) wr_ptr <= ~wr_ptr;
      if (reading) rd_ptr <= ~rd_ptr;
      if (writing && !reading) count <= count + 2'd1;
      else if (reading && !writing) count <= count - 2'd1;
    end
  end

endmodule

@@ rtl/tensor_shape_word_decoder_unit.sv @@
// channel   | handshake            | payload
// ----------+----------------------+----------------------------------------
// input     | push / full          | word
// result    | empty / pop          | axis, dim, max_dim, pad, flags, last
// config    | cfg_valid / cfg_ready| axis_count
//
// a word is registered in the 2-entry word queue, then the sequencer takes
// it; the axis walker then emits the axes one at a time and moves on to wait
// for the next word when an axis needs one or when the record ends.
// synchronous reset empties both 2-entry queues, the sequencer expects the
// first word of a record and the stored axis count returns to 1.
// a full result queue stalls the walker; the word queue takes input until its
// two entries fill.
module tensor_shape_word_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [31:0] word,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  axis,
  output logic [31:0] dim,
  output logic [31:0] max_dim,
  output logic [7:0]  pad,
  output logic [15:0] flags,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  axis_count
);
  import tswd_pkg::*;

  logic [2:0]  rank_setting;
  logic        head_valid;
  word_entry_t head_entry;
  logic        head_take;
  logic        res_valid;
  result_t     res;
  logic        res_full;
  result_t     out_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_setting <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      rank_setting <= axis_count;
    end
  end

  tswd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .word       (word),
    .full       (full),
    .head_valid (head_valid),
    .head       (head_entry),
    .head_take  (head_take)
  );

  tswd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .rank_setting (rank_setting),
    .head_valid   (head_valid),
    .head         (head_entry),
    .head_take    (head_take),
    .res_valid    (res_valid),
    .res          (res),
    .res_full     (res_full)
  );

  tswd_out_q u_out_q (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_full  (res_full),
    .empty     (empty),
    .head      (out_head),
    .pop       (pop)
  );

  assign axis    = out_head.axis;
  assign dim     = out_head.dim;
  assign max_dim = out_head.max_dim;
  assign pad     = out_head.pad;
  assign flags   = out_head.flags;
  assign last    = out_head.last;

endmodule

@@ rtl/tswd_checker.sv @@
module tswd_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  axis,
  input logic [31:0] dim,
  input logic        last
);

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(axis) && $stable(dim) && $stable(last))
    else $error("waiting result changed");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> axis <= 3'd5)
    else $error("axis index out of range");

  // the sixth axis always closes a record
  a_final_axis: assert property (@(posedge clk) disable iff (rst)
    !empty && axis == 3'd5 |-> last)
    else $error("axis 5 not marked last");

endmodule

bind tensor_shape_word_decoder_unit tswd_checker u_tswd_checker (
  .clk   (clk),
  .rst   (rst),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .axis  (axis),
  .dim   (dim),
  .last  (last)
);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import tswd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_PAUSE = 10;
  localparam int WORDS_PER_PHASE = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [31:0] word = '0;
  logic        full;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  axis;
  logic [31:0] dim;
  logic [31:0] max_dim;
  logic [7:0]  pad;
  logic [15:0] flags;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  axis_count = 3'd1;

  tensor_shape_word_decoder_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .word       (word),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .axis       (axis),
    .dim        (dim),
    .max_dim    (max_dim),
    .pad        (pad),
    .flags      (flags),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .axis_count (axis_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // words waiting to be sent, and axis results the decoder should produce
  logic [31:0] word_feed_q[$];
  result_t     axis_results_q[$];

  int unsigned mismatch_count = 0;
  int unsigned words_sent = 0;
  int unsigned axes_checked = 0;
  int unsigned rank_writes = 0;
  int unsigned cycle_count = 0;

  // shadow of the shape decoder
  logic [2:0]   rank_reg = 3'd1;
  back_state_t  pred_phase = ST_FIRST;
  logic [2:0]   pred_axis = '0;
  logic [23:0]  pred_ctrl = '0;
  logic [15:0]  pred_flags = '0;
  logic [31:0]  pred_dim = '0;
  logic [31:0]  pred_max = '0;
  logic [7:0]   pred_pad = '0;

  function automatic int cur_rank();
    if (rank_reg == 3'd0) return 1;
    else if (int'(rank_reg) > MAX_AXES) return MAX_AXES;
    else return int'(rank_reg);
  endfunction

  function automatic logic [3:0] cur_group();
    return 4'(pred_ctrl >> (4 * pred_axis));
  endfunction

  // stage 0: new axis, 1: base values known, 2: max settled, 3: pad settled
  task automatic walk_axes(input int stage);
    logic [3:0] grp;
    logic       fin;
    result_t    res;
    bit         done;
    done = 1'b0;
    while (!done) begin
      grp = cur_group();
      if (stage == 0) begin
        if (axis_mode_t'(grp[1:0]) != MODE_NONE) begin
          pred_phase = ST_DIM;
          done = 1'b1;
        end else begin
          pred_dim = 32'd1;
          pred_max = 32'd1;
          pred_pad = 8'd0;
          stage = 1;
        end
      end
      if (!done && stage == 1) begin
        if (grp[2]) begin
          pred_phase = ST_MAXW;
          done = 1'b1;
        end else begin
          stage = 2;
        end
      end
      if (!done && stage == 2 && grp[3]) begin
        pred_phase = ST_PADW;
        done = 1'b1;
      end
      if (!done) begin
        fin = (int'(pred_axis) + 1) >= cur_rank();
        res.axis    = pred_axis;
        res.dim     = pred_dim;
        res.max_dim = pred_max;
        res.pad     = pred_pad;
        res.flags   = pred_flags;
        res.last    = fin;
        axis_results_q.push_back(res);
        if (fin) begin
          pred_phase = ST_FIRST;
          pred_flags = '0;
          pred_axis = '0;
          done = 1'b1;
        end else begin
          pred_axis = pred_axis + 3'd1;
          stage = 0;
        end
      end
    end
  endtask

  task automatic decode_shape_word(input logic [31:0] w);
    axis_mode_t mode;
    bit         take_ctrl;
    take_ctrl = 1'b0;
    case (pred_phase)
      ST_CONTROL: take_ctrl = 1'b1;
      ST_DIM: begin
        mode = axis_mode_t'(cur_group() & 4'h3);
        case (mode)
          MODE_DIM16: begin
            pred_dim = {16'd0, w[15:0]};
            pred_max = {16'd0, w[15:0]} + {24'd0, w[23:16]};
            pred_pad = w[31:24];
          end
          MODE_DIM24: begin
            pred_dim = {8'd0, w[23:0]};
            pred_max = {8'd0, w[23:0]};
            pred_pad = w[31:24];
          end
          default: begin
            pred_dim = w;
            pred_max = w;
            pred_pad = 8'd0;
          end
        endcase
        walk_axes(1);
      end
      ST_MAXW: begin
        pred_max = w;
        walk_axes(2);
      end
      ST_PADW: begin
        pred_pad = w[7:0];
        walk_axes(3);
      end
      default: begin
        if (w[31:16] == FLAGS_PREFIX) begin
          pred_flags = w[15:0];
          pred_phase = ST_CONTROL;
        end else begin
          pred_flags = '0;
          take_ctrl = 1'b1;
        end
      end
    endcase
    if (take_ctrl) begin
      pred_ctrl = w[23:0];
      pred_axis = '0;
      walk_axes(0);
    end
  endtask

  // sender: bursts of random length separated by random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        decode_shape_word(word);
        void'(word_feed_q.pop_front());
        words_sent++;
      end
      if (!(push && full)) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (word_feed_q.size() > 0) begin
          push <= 1'b1;
          word <= word_feed_q[0];
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 10);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // receiver: pop pattern rotates through four stall modes
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (axis_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual axis %0d dim %0h",
                   $time, axis, dim);
          mismatch_count++;
        end else begin
          want = axis_results_q.pop_front();
          check_field("axis", 32'(want.axis), 32'(axis));
          check_field("dim", want.dim, dim);
          check_field("max_dim", want.max_dim, max_dim);
          check_field("pad", 32'(want.pad), 32'(pad));
          check_field("flags", 32'(want.flags), 32'(flags));
          check_field("last", 32'(want.last), 32'(last));
          axes_checked++;
        end
      end
      case ((cycle_count / 64) % 4)
        0: pop <= 1'b1;
        1: pop <= $urandom_range(0, 1);
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= cycle_count[3];
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               axis_results_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // wait until every queued word is taken and every result has come out
  task automatic drain();
    do @(posedge clk);
    while (word_feed_q.size() != 0 || push || axis_results_q.size() != 0);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_rank(input logic [2:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    axis_count <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    rank_reg = value;
    rank_writes++;
  endtask

  task automatic gen_record(input int rank, input bit broken);
    logic [31:0] rec[$];
    logic [31:0] ctrl;
    logic [3:0]  grp;
    int          keep;
    if ($urandom_range(0, 1)) rec.push_back({FLAGS_PREFIX, 16'($urandom())});
    ctrl = $urandom();
    if ($urandom_range(0, 7) == 0) ctrl[31:16] = FLAGS_PREFIX;
    rec.push_back(ctrl);
    for (int a = 0; a < rank; a++) begin
      grp = 4'(ctrl >> (4 * a));
      if (grp[1:0] != 2'd0) rec.push_back($urandom());
      if (grp[2]) rec.push_back($urandom());
      if (grp[3]) rec.push_back($urandom());
    end
    keep = broken ? $urandom_range(1, rec.size()) : rec.size();
    for (int i = 0; i < keep; i++) word_feed_q.push_back(rec[i]);
  endtask

  logic [2:0] rank_plan[10] = '{3'd1, 3'd6, 3'd3, 3'd0, 3'd7, 3'd2, 3'd5, 3'd4,
                                3'd6, 3'd1};

  initial begin
    int mark;
    int pick;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // rank 1 from reset: every mode, overrides, field extremes
    word_feed_q = '{32'h0000_0000, 32'hff00_0000,
                    32'hcccc_ffff, 32'hcccc_0003, 32'hffff_ffff,
                    32'h0000_0001, 32'hffff_ffff,
                    32'h0000_0001, 32'h0000_0000,
                    32'h0000_0002, 32'hffff_ffff,
                    32'hcccc_0000, 32'h0000_000f, 32'h0000_0000, 32'hffff_ffff,
                    32'h0000_00ab,
                    32'h0000_0008, 32'hffff_ffff,
                    32'h0000_0004, 32'h1234_5678};
    drain();
    write_rank(3'd6);
    // all six axes wordless, then a record left waiting at axis 2
    word_feed_q.push_back(32'h0000_0000);
    word_feed_q.push_back(32'h0000_0300);
    drain();
    // lower the rank in the middle of that record
    write_rank(3'd2);
    word_feed_q.push_back(32'h0000_00ff);
    drain();
    write_rank(3'd0);
    word_feed_q.push_back(32'h0000_0000);
    drain();
    write_rank(3'd7);
    word_feed_q.push_back(32'h0000_0000);
    drain();

    foreach (rank_plan[p]) begin
      write_rank(rank_plan[p]);
      mark = words_sent + word_feed_q.size();
      while (words_sent + word_feed_q.size() < mark + WORDS_PER_PHASE) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) word_feed_q.push_back($urandom());
        else gen_record(cur_rank(), pick == 1);
      end
      drain();
    end

    $display("%0d words sent across %0d rank settings, %0d axis results checked",
             words_sent, rank_writes, axes_checked);
    if (mismatch_count == 0 && axis_results_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count,
               axis_results_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
